// ===== rtl/core/ffsa_pkg.sv =====
// Package with the shared types and codes of the first-fit segment allocator.
`timescale 1ns / 1ps

package ffsa_pkg;

	localparam int FIELD_BITS = 16;
	localparam logic [15:0] HEAP_RESET = 16'd1024;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NOFIT = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_SCAN,
		S_FNXT,
		S_SHUP,
		S_WHI,
		S_WLO,
		S_SHDN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic rd;
		logic wr;
	} mem_en_t;

endpackage

// ===== rtl/core/ffsa_if.sv =====
// Request and result channel interfaces of the segment allocator.
`timescale 1ns / 1ps

interface ffsa_req_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [15:0] owner_id;
	logic [15:0] request_size;
	logic [15:0] free_offset;

	modport source (output valid, mode, owner_id, request_size, free_offset, input ready);
	modport sink (input valid, mode, owner_id, request_size, free_offset, output ready);
endinterface

interface ffsa_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] alloc_offset;

	modport source (output valid, status, alloc_offset, input ready);
	modport sink (input valid, status, alloc_offset, output ready);
endinterface

// ===== rtl/core/ffsa_seg_mem.sv =====
// Segment table memory: one write port and one registered read port.
`timescale 1ns / 1ps

module ffsa_seg_mem
	import ffsa_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int DW = 49,
	parameter int AW = 6
) (
	input  logic          clk,
	input  mem_en_t       en,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en.wr) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (en.rd) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/first_fit_segment_allocator.sv =====
// Top level of the first-fit segment allocator with coalescing.
//
//  Channel  | Direction | Handshake      | Payload
//  ---------+-----------+----------------+-----------------------------------------
//  req      | in        | valid/ready    | mode, owner_id, request_size, free_offset
//  rsp      | out       | valid/ready    | status, alloc_offset
//  cfg      | in        | cfg_we only    | cfg_wdata = heap_size
//
// One request is worked on at a time. A request scans the segment table at one
// entry per cycle through the registered read port. A split shifts the tail up
// by one entry per cycle and a merge shifts it down the same way; the scan
// stops where the shift starts. A zero-size allocate skips the scan, and a
// finished request may wait for the result register.
// After reset and after each heap_size write the block writes the single free
// segment into entry 0; requests are held off while it does so.
// The result register frees the controller: a new request transfer is taken
// while a finished result still waits for the sink.
`timescale 1ns / 1ps

module first_fit_segment_allocator
	import ffsa_pkg::*;
#(
	parameter int MAX_SEGMENTS = 64,
	parameter int OFFSET_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [15:0]  cfg_wdata,
	ffsa_req_if.sink     req,
	ffsa_rsp_if.source   rsp
);

	localparam int OB = OFFSET_BITS;
	localparam int IW = $clog2(MAX_SEGMENTS);
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam int DW = 1 + FIELD_BITS + 2 * OB;
	localparam int W  = (OB > FIELD_BITS) ? OB : FIELD_BITS;
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SEGMENTS);
	localparam logic [CW-1:0] CNT_ONE = CW'(1);

	state_t state_q, state_d;

	logic [15:0]    heap_q;
	logic [CW-1:0]  cnt_q;
	logic [CW-1:0]  scan_q;
	logic           chk_v_s1;
	logic [IW-1:0]  chk_idx_s1;
	logic [DW-1:0]  prev_q;
	logic [DW-1:0]  cur_q;
	logic [IW-1:0]  hit_q;
	logic           has_next_q;
	logic           pfree_q;
	logic           mode_q;
	logic [15:0]    id_q;
	logic [15:0]    rsz_q;
	logic [15:0]    fofs_q;
	logic [CW-1:0]  p_q;
	logic           wv_s1;
	logic [IW-1:0]  wa_s1;
	logic [1:0]     dlt_q;
	logic [1:0]     st_q;
	logic [15:0]    rofs_q;
	logic           ov_q;
	logic [1:0]     ost_q;
	logic [15:0]    oofs_q;

	mem_en_t        en;
	logic [IW-1:0]  raddr, waddr;
	logic [DW-1:0]  rdata, wdata;

	ffsa_seg_mem #(
		.DEPTH(MAX_SEGMENTS),
		.DW(DW),
		.AW(IW)
	) u_mem (
		.clk(clk),
		.en(en),
		.raddr(raddr),
		.rdata(rdata),
		.waddr(waddr),
		.wdata(wdata)
	);

	// Fields of the entry on the read port and of the saved hit entry.
	logic          r_used;
	logic [15:0]   r_own;
	logic [OB-1:0] r_size, r_ofs, c_size, c_ofs, p_size, p_ofs;

	assign r_used = rdata[DW-1];
	assign r_own  = rdata[DW-2 -: FIELD_BITS];
	assign r_size = rdata[2*OB-1 -: OB];
	assign r_ofs  = rdata[OB-1:0];
	assign c_size = cur_q[2*OB-1 -: OB];
	assign c_ofs  = cur_q[OB-1:0];
	assign p_size = prev_q[2*OB-1 -: OB];
	assign p_ofs  = prev_q[OB-1:0];

	logic rd_more, a_fit, a_exact, f_match, hit, scan_fail, nfree, out_free;

	assign rd_more   = scan_q < cnt_q;
	assign a_fit     = !r_used && (W'(r_size) >= W'(rsz_q));
	assign a_exact   = W'(r_size) == W'(rsz_q);
	assign f_match   = r_used && (r_own == id_q) && (W'(r_ofs) == W'(fofs_q));
	assign hit       = chk_v_s1 && ((mode_q == MODE_FREE) ? f_match : a_fit);
	assign scan_fail = !chk_v_s1 && !rd_more;
	assign nfree     = has_next_q && !r_used;
	assign out_free  = !ov_q || rsp.ready;

	// Pointer arithmetic for the shift passes.
	logic [CW-1:0] hit_c;
	assign hit_c = CW'(hit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory port control.
	always_comb begin
		state_d   = state_q;
		en        = '0;
		raddr     = scan_q[IW-1:0];
		waddr     = hit_q;
		wdata     = '0;
		req.ready = 1'b0;
		unique case (state_q)
			S_INIT: begin
				en.wr   = 1'b1;
				waddr   = '0;
				wdata   = {1'b0, 16'd0, OB'(heap_q), {OB{1'b0}}};
				state_d = S_IDLE;
			end
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					if (req.mode == MODE_ALLOC && req.request_size == 16'd0) begin
						state_d = S_DONE;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				en.rd = rd_more;
				raddr = scan_q[IW-1:0];
				if (hit) begin
					if (mode_q == MODE_FREE) begin
						state_d = S_FNXT;
					end else if (a_exact) begin
						en.wr   = 1'b1;
						waddr   = chk_idx_s1;
						wdata   = {1'b1, id_q, r_size, r_ofs};
						state_d = S_DONE;
					end else if (cnt_q == CNT_MAX) begin
						state_d = S_DONE;
					end else begin
						state_d = S_SHUP;
					end
				end else if (scan_fail) begin
					state_d = S_DONE;
				end
			end
			S_SHUP: begin
				en.wr = wv_s1;
				waddr = wa_s1;
				wdata = rdata;
				raddr = p_q[IW-1:0];
				if (p_q > hit_c) begin
					en.rd = 1'b1;
				end else if (!wv_s1) begin
					state_d = S_WHI;
				end
			end
			S_WHI: begin
				en.wr   = 1'b1;
				waddr   = IW'(hit_c + CNT_ONE);
				wdata   = {1'b0, 16'd0, OB'(W'(c_size) - W'(rsz_q)),
					OB'(W'(c_ofs) + W'(rsz_q))};
				state_d = S_WLO;
			end
			S_WLO: begin
				en.wr   = 1'b1;
				waddr   = hit_q;
				wdata   = {1'b1, id_q, OB'(rsz_q), c_ofs};
				state_d = S_DONE;
			end
			S_FNXT: begin
				en.wr = 1'b1;
				if (pfree_q && nfree) begin
					waddr   = IW'(hit_c - CNT_ONE);
					wdata   = {1'b0, 16'd0, OB'(p_size + c_size + r_size), p_ofs};
					state_d = S_SHDN;
				end else if (nfree) begin
					waddr   = hit_q;
					wdata   = {1'b0, 16'd0, OB'(c_size + r_size), c_ofs};
					state_d = S_SHDN;
				end else if (pfree_q) begin
					waddr   = IW'(hit_c - CNT_ONE);
					wdata   = {1'b0, 16'd0, OB'(p_size + c_size), p_ofs};
					state_d = S_SHDN;
				end else begin
					waddr   = hit_q;
					wdata   = {1'b0, 16'd0, c_size, c_ofs};
					state_d = S_DONE;
				end
			end
			S_SHDN: begin
				en.wr = wv_s1;
				waddr = wa_s1;
				wdata = rdata;
				raddr = p_q[IW-1:0];
				if (p_q < cnt_q) begin
					en.rd = 1'b1;
				end else if (!wv_s1) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_INIT;
		endcase
		if (cfg_we) begin
			state_d = S_INIT;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_q   <= HEAP_RESET;
			cnt_q    <= CNT_ONE;
			scan_q   <= '0;
			chk_v_s1 <= 1'b0;
			wv_s1    <= 1'b0;
			p_q      <= '0;
			dlt_q    <= '0;
			ov_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				heap_q <= cfg_wdata;
			end
			if (rsp.valid && rsp.ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					cnt_q <= CNT_ONE;
				end
				S_IDLE: begin
					scan_q   <= '0;
					chk_v_s1 <= 1'b0;
				end
				S_SCAN: begin
					chk_v_s1 <= rd_more;
					if (rd_more) begin
						scan_q <= scan_q + CNT_ONE;
					end
					p_q   <= cnt_q - CNT_ONE;
					wv_s1 <= 1'b0;
				end
				S_SHUP: begin
					if (p_q > hit_c) begin
						wv_s1 <= 1'b1;
						p_q   <= p_q - CNT_ONE;
					end else begin
						wv_s1 <= 1'b0;
					end
				end
				S_WLO: begin
					cnt_q <= cnt_q + CNT_ONE;
				end
				S_FNXT: begin
					wv_s1 <= 1'b0;
					if (pfree_q && nfree) begin
						dlt_q <= 2'd2;
						p_q   <= hit_c + CW'(2);
					end else if (nfree) begin
						dlt_q <= 2'd1;
						p_q   <= hit_c + CW'(2);
					end else begin
						dlt_q <= 2'd1;
						p_q   <= hit_c + CNT_ONE;
					end
				end
				S_SHDN: begin
					if (p_q < cnt_q) begin
						wv_s1 <= 1'b1;
						p_q   <= p_q + CNT_ONE;
					end else begin
						wv_s1 <= 1'b0;
						if (!wv_s1) begin
							cnt_q <= cnt_q - CW'(dlt_q);
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						ov_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers. The previous entry is held across the hit so that a
	// merge with a free predecessor sees its size and offset.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				mode_q <= req.mode;
				id_q   <= req.owner_id;
				rsz_q  <= req.request_size;
				fofs_q <= req.free_offset;
				st_q   <= ST_NOFIT;
				rofs_q <= '0;
			end
			S_SCAN: begin
				chk_idx_s1 <= scan_q[IW-1:0];
				if (chk_v_s1 && !hit) begin
					prev_q <= rdata;
				end
				if (hit) begin
					cur_q      <= rdata;
					hit_q      <= chk_idx_s1;
					has_next_q <= rd_more;
					pfree_q    <= (chk_idx_s1 != '0) && !prev_q[DW-1];
					if (mode_q == MODE_FREE) begin
						st_q <= ST_OK;
					end else if (a_exact) begin
						st_q   <= ST_OK;
						rofs_q <= 16'(r_ofs);
					end else if (cnt_q == CNT_MAX) begin
						st_q <= ST_FULL;
					end
				end
			end
			S_SHUP: begin
				wa_s1 <= IW'(p_q + CNT_ONE);
			end
			S_SHDN: begin
				wa_s1 <= IW'(p_q - CW'(dlt_q));
			end
			S_WLO: begin
				st_q   <= ST_OK;
				rofs_q <= 16'(c_ofs);
			end
			S_DONE: begin
				if (out_free) begin
					ost_q  <= st_q;
					oofs_q <= rofs_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid        = ov_q;
	assign rsp.status       = ost_q;
	assign rsp.alloc_offset = oofs_q;

	// The table never holds more entries than the memory has rows, nor none.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q <= CNT_MAX) && (cnt_q != '0))
		else $error("segment count out of range");

	// A table-full result is only reported when the table really is full.
	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_free && st_q == ST_FULL) |-> (cnt_q == CNT_MAX))
		else $error("table full reported with room left");

	// A nonzero offset only comes with a successful allocation.
	a_ofs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && oofs_q != 16'd0) |-> (ost_q == ST_OK))
		else $error("offset returned on a failed request");

	// The upward shift never writes past the end of the grown table.
	a_shup_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHUP && wv_s1) |-> (CW'(wa_s1) <= cnt_q))
		else $error("shift write beyond table end");

endmodule

// ===== tb/sv/first_fit_segment_allocator_tb.sv =====
// Self-checking testbench for the first-fit segment allocator with coalescing.
`timescale 1ns / 1ps

module first_fit_segment_allocator_tb;
	import ffsa_pkg::*;

	localparam int NSEG = 64;

	// Expected response of one request.
	typedef struct {
		logic [1:0]  status;
		logic [15:0] alloc_offset;
	} alloc_rsp_t;

	// The scoreboard keeps its own copy of the segment table and the queue of
	// responses still owed by the block.
	class segment_scoreboard;
		logic        used [NSEG];
		logic [15:0] owner [NSEG];
		logic [15:0] size [NSEG];
		logic [15:0] base [NSEG];
		int          count;
		alloc_rsp_t  pending [$];
		int          errors;

		function void init_heap(logic [15:0] heap);
			for (int k = 0; k < NSEG; k++) begin
				used[k] = 1'b0;
				owner[k] = '0;
				size[k] = '0;
				base[k] = '0;
			end
			size[0] = heap;
			count = 1;
		endfunction

		function void remove_at(int k);
			for (int j = k; j + 1 < count; j++) begin
				used[j] = used[j + 1];
				owner[j] = owner[j + 1];
				size[j] = size[j + 1];
				base[j] = base[j + 1];
			end
			count--;
		endfunction

		function alloc_rsp_t allocate(logic [15:0] id, logic [15:0] want);
			alloc_rsp_t r;
			r.status = ST_NOFIT;
			r.alloc_offset = '0;
			if (want == 0)
				return r;
			for (int i = 0; i < count; i++) begin
				if (used[i] || size[i] < want)
					continue;
				if (size[i] == want) begin
					used[i] = 1'b1;
					owner[i] = id;
					r.status = ST_OK;
					r.alloc_offset = base[i];
					return r;
				end
				if (count >= NSEG) begin
					r.status = ST_FULL;
					return r;
				end
				for (int j = count; j > i + 1; j--) begin
					used[j] = used[j - 1];
					owner[j] = owner[j - 1];
					size[j] = size[j - 1];
					base[j] = base[j - 1];
				end
				used[i + 1] = 1'b0;
				owner[i + 1] = '0;
				size[i + 1] = size[i] - want;
				base[i + 1] = base[i] + want;
				used[i] = 1'b1;
				owner[i] = id;
				size[i] = want;
				count++;
				r.status = ST_OK;
				r.alloc_offset = base[i];
				return r;
			end
			return r;
		endfunction

		function alloc_rsp_t release_seg(logic [15:0] id, logic [15:0] ofs);
			alloc_rsp_t r;
			r.status = ST_NOFIT;
			r.alloc_offset = '0;
			for (int i = 0; i < count; i++) begin
				if (!used[i] || owner[i] != id || base[i] != ofs)
					continue;
				used[i] = 1'b0;
				owner[i] = '0;
				if (i + 1 < count && !used[i + 1]) begin
					size[i] = size[i] + size[i + 1];
					remove_at(i + 1);
				end
				if (i > 0 && !used[i - 1]) begin
					size[i - 1] = size[i - 1] + size[i];
					remove_at(i);
				end
				r.status = ST_OK;
				return r;
			end
			return r;
		endfunction

		// Notes an accepted request and queues the response it must cause.
		function void note_request(logic m, logic [15:0] id, logic [15:0] want,
				logic [15:0] ofs);
			pending.push_back(m == MODE_ALLOC ? allocate(id, want) : release_seg(id, ofs));
		endfunction

		// Compares one response transfer with the oldest expectation.
		function void check_response(logic [1:0] st, logic [15:0] ofs);
			alloc_rsp_t e;
			if (pending.size() == 0) begin
				report("response with nothing expected");
				return;
			end
			e = pending.pop_front();
			if (st !== e.status)
				report($sformatf("status %0d, expected %0d", st, e.status));
			if (ofs !== e.alloc_offset)
				report($sformatf("offset %0d, expected %0d", ofs, e.alloc_offset));
		endfunction

		function void report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;

	ffsa_req_if req ();
	ffsa_rsp_if rsp ();

	first_fit_segment_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req.sink),
		.rsp       (rsp.source)
	);

	always #10 clk = ~clk;

	segment_scoreboard board = new();

	// Offsets and owners of segments believed to be allocated, so that most
	// frees hit a live segment and drive the merge paths.
	logic [15:0] live_ofs [$];
	logic [15:0] live_id [$];
	logic [15:0] heap_now;
	int          burst_left;

	initial begin
		req.valid = 1'b0;
		req.mode = MODE_ALLOC;
		req.owner_id = '0;
		req.request_size = '0;
		req.free_offset = '0;
		rsp.ready = 1'b0;
	end

	// The receiver stalls on a pattern of its own: long free-running stretches
	// alternate with stretches of random back-pressure.
	int rx_phase = 0;
	always @(posedge clk) begin
		rx_phase <= rx_phase + 1;
		if ((rx_phase / 300) % 3 == 0)
			rsp.ready <= 1'b1;
		else
			rsp.ready <= ($urandom_range(0, 3) != 0);
	end

	// Every response transfer is checked at the edge where it happens.
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready)
			board.check_response(rsp.status, rsp.alloc_offset);
	end

	// Sends one request transfer. The sender works in bursts: once a burst is
	// used up it drops valid for a random gap before the next one starts.
	task automatic send_request(logic m, logic [15:0] id, logic [15:0] want,
			logic [15:0] ofs);
		if (burst_left == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		req.valid <= 1'b1;
		req.mode <= m;
		req.owner_id <= id;
		req.request_size <= want;
		req.free_offset <= ofs;
		do @(posedge clk); while (!req.ready);
		board.note_request(m, id, want, ofs);
		if (m == MODE_ALLOC) begin
			if (board.pending[$].status == ST_OK) begin
				live_ofs.push_back(board.pending[$].alloc_offset);
				live_id.push_back(id);
			end
		end else if (board.pending[$].status == ST_OK) begin
			for (int k = 0; k < live_ofs.size(); k++)
				if (live_ofs[k] == ofs && live_id[k] == id) begin
					live_ofs.delete(k);
					live_id.delete(k);
					break;
				end
		end
	endtask

	// Lowers valid and waits until every owed response has come back.
	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (2 * NSEG + 10) @(posedge clk);
	endtask

	// Writes heap_size while the block is idle and restarts the model.
	task automatic set_heap(logic [15:0] heap);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= heap;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.init_heap(heap);
		heap_now = heap;
		live_ofs.delete();
		live_id.delete();
	endtask

	// One random request: mostly allocations sized to the heap and frees of
	// live segments, with some stray frees and full-range noise.
	task automatic random_request();
		int pick;
		int k;
		int cap;
		pick = $urandom_range(0, 99);
		cap = (heap_now > 64) ? heap_now / 16 : heap_now + 1;
		if (pick < 50)
			send_request(MODE_ALLOC, 16'($urandom_range(0, 7)),
				16'($urandom_range(1, cap)), 16'($urandom));
		else if (pick < 88 && live_ofs.size() != 0) begin
			k = $urandom_range(0, live_ofs.size() - 1);
			send_request(MODE_FREE, live_id[k], 16'($urandom), live_ofs[k]);
		end else if (pick < 94)
			send_request(MODE_FREE, 16'($urandom_range(0, 7)), 16'($urandom),
				16'($urandom_range(0, heap_now)));
		else
			send_request(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
				16'($urandom));
	endtask

	initial begin
		board.errors = 0;
		board.init_heap(HEAP_RESET);
		heap_now = HEAP_RESET;
		burst_left = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part on the reset heap: zero size, exact fit of the whole
		// heap, oversized request, a free with the wrong owner, a free of the
		// whole heap, and a free between two free neighbors.
		send_request(MODE_ALLOC, 16'd1, 16'd0, 16'd0);
		send_request(MODE_ALLOC, 16'd1, 16'hFFFF, 16'd0);
		send_request(MODE_ALLOC, 16'hFFFF, 16'd1024, 16'd0);
		send_request(MODE_FREE, 16'd1, 16'd0, 16'd0);
		send_request(MODE_FREE, 16'hFFFF, 16'hFFFF, 16'd0);
		send_request(MODE_ALLOC, 16'd2, 16'd100, 16'hFFFF);
		send_request(MODE_ALLOC, 16'd3, 16'd100, 16'd0);
		send_request(MODE_ALLOC, 16'd4, 16'd100, 16'd0);
		send_request(MODE_FREE, 16'd2, 16'd0, 16'd0);
		send_request(MODE_FREE, 16'd4, 16'd0, 16'd200);
		send_request(MODE_FREE, 16'd3, 16'd0, 16'd100);

		// A zero heap fits nothing.
		set_heap(16'd0);
		send_request(MODE_ALLOC, 16'd1, 16'd1, 16'd0);
		send_request(MODE_FREE, 16'd0, 16'd0, 16'd0);

		// Fill a 64-entry table with unit splits; the next split reports a full
		// table while an exact fit on the tail still succeeds.
		set_heap(16'd70);
		for (int n = 0; n < 63; n++)
			send_request(MODE_ALLOC, 16'd9, 16'd1, 16'd0);
		send_request(MODE_ALLOC, 16'd9, 16'd1, 16'd0);
		send_request(MODE_ALLOC, 16'd9, 16'd7, 16'd0);

		// Full-scale heap, then the pause with every response returned.
		set_heap(16'hFFFF);
		send_request(MODE_ALLOC, 16'hFFFF, 16'hFFFF, 16'd0);
		send_request(MODE_FREE, 16'hFFFF, 16'd0, 16'd0);
		drain();

		// Random phases over several heap sizes, from tiny to the maximum.
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: set_heap(16'd1);
				1: set_heap(16'd40);
				2: set_heap(16'd1024);
				3: set_heap(16'd300);
				4: set_heap(16'hFFFF);
				default: set_heap(16'($urandom_range(2, 65534)));
			endcase
			for (int n = 0; n < 280; n++)
				random_request();
		end

		drain();
		if (board.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// The slowest correct run is about 1800 transfers plus stalls and gaps;
	// this limit is many times that.
	initial begin
		#100ms;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
